// ===== design/lbsc_pkg.sv =====
// Shared constants, types and state codes for the line box-sum block.
package lbsc_pkg;

  localparam int MAX_RADIUS  = 31;
  localparam int SAMPLE_BITS = 16;
  localparam int STORE_DEPTH = 2 * MAX_RADIUS + 1;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int R_W         = $clog2(MAX_RADIUS + 1);
  localparam int SUM_W       = SAMPLE_BITS + $clog2(STORE_DEPTH);
  localparam int CFG_W       = 5;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]       sum_t;

  // Control broadcast along the row of delay cells.
  typedef struct packed {
    logic             fill;
    logic             shift;
    logic [IDX_W-1:0] entry;
    sample_t          sample;
  } line_ctl_t;

  typedef enum logic [1:0] {
    ST_RUN   = 2'b01,
    ST_FLUSH = 2'b10
  } state_t;

endpackage

// ===== design/lbsc_ifs.sv =====
// Valid/ready channel interfaces for the sample and sum words.
interface lbsc_in_if;
  logic                 valid;
  logic                 ready;
  lbsc_pkg::sample_t    sample;
  logic                 line_end;

  modport source (output valid, output sample, output line_end, input ready);
  modport sink   (input valid, input sample, input line_end, output ready);
endinterface

interface lbsc_out_if;
  logic                 valid;
  logic                 ready;
  lbsc_pkg::sum_t       window_sum;
  logic                 last_of_line;

  modport source (output valid, output window_sum, output last_of_line, input ready);
  modport sink   (input valid, input window_sum, input last_of_line, output ready);
endinterface

// ===== design/lbsc_cell.sv =====
// One delay cell: holds a sample and takes its neighbour's or a new one.
module lbsc_cell (
  input  logic                      clk,
  input  lbsc_pkg::line_ctl_t       ctl,
  input  logic [lbsc_pkg::IDX_W-1:0] idx,
  input  lbsc_pkg::sample_t         prev,
  output lbsc_pkg::sample_t         q
);

  always_ff @(posedge clk) begin
    if (ctl.fill) begin
      q <= ctl.sample;
    end else if (ctl.shift) begin
      // The new word enters at the cell that makes the line 2R+1 deep.
      q <= (ctl.entry == idx) ? ctl.sample : prev;
    end
  end

endmodule

// ===== design/lbsc_delay_line.sv =====
// Row of delay cells whose far end gives the word leaving the window.
module lbsc_delay_line (
  input  logic                clk,
  input  lbsc_pkg::line_ctl_t ctl,
  output lbsc_pkg::sample_t   tail
);

  lbsc_pkg::sample_t d [lbsc_pkg::STORE_DEPTH];

  for (genvar j = 0; j < lbsc_pkg::STORE_DEPTH; j++) begin : g_cell
    lbsc_pkg::sample_t prev;
    if (j == 0) begin : g_head
      assign prev = ctl.sample;
    end else begin : g_body
      assign prev = d[j-1];
    end
    lbsc_cell u_cell (
      .clk  (clk),
      .ctl  (ctl),
      .idx  (lbsc_pkg::IDX_W'(j)),
      .prev (prev),
      .q    (d[j])
    );
  end

  assign tail = d[lbsc_pkg::STORE_DEPTH-1];

endmodule

// ===== design/lbsc_accum.sv =====
// Running window total: preset to (2R+1) copies of the first sample, then add and drop.
module lbsc_accum (
  input  logic                     clk,
  input  logic                     fill,
  input  logic                     step,
  input  logic [lbsc_pkg::R_W-1:0] radius,
  input  lbsc_pkg::sample_t        push,
  input  lbsc_pkg::sample_t        drop,
  output lbsc_pkg::sum_t           total_next
);

  localparam int PROD_W = lbsc_pkg::SAMPLE_BITS + lbsc_pkg::R_W + 2;

  lbsc_pkg::sum_t              total;
  logic signed [lbsc_pkg::R_W+1:0] span;
  logic signed [PROD_W-1:0]    prod;

  always_comb begin
    span = $signed({1'b0, radius, 1'b1});
    prod = span * push;
    if (fill) begin
      total_next = lbsc_pkg::SUM_W'(prod);
    end else begin
      total_next = total + lbsc_pkg::SUM_W'(push) - lbsc_pkg::SUM_W'(drop);
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      total <= total_next;
    end
  end

endmodule

// ===== design/line_box_sum_clamped_edges.sv =====
// Top level of the streaming line box sum with replicated borders.
//
// Samples of one grid line arrive on the samples channel, one word per
// handshake, with line_end set on the last one. For each position the block
// returns on the sums channel the sum of the 2R+1 samples centred there, the
// first and last samples standing in past the ends of the line.
// Radius R is written through cfg_we/cfg_wdata and is latched at the first
// sample of each line; values above the maximum are used as the maximum.
// Within a line a sample is taken every cycle unless the receiver stalls. The
// sum for position p leaves on the cycle after sample p+R is taken. The last
// sample of a line starts a flush of R further steps during which the samples
// channel is not ready; each flush step gives one result, except that a line of
// L <= R samples gives none in its first R-L flush steps. With R = 0 there is no
// flush. The flush length is set by the radius latched for the line; the row of
// delay cells takes one word per cycle while the pipeline advances.
// A single output register holds each result; while the receiver stalls, the
// whole pipeline holds and samples is not ready.
// Reset (rst, synchronous) empties the output, restarts at the first sample
// of a line and sets the radius to 1.
module line_box_sum_clamped_edges (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [lbsc_pkg::CFG_W-1:0] cfg_wdata,
  lbsc_in_if.sink                    samples,
  lbsc_out_if.source                 sums
);

  localparam int R_W = lbsc_pkg::R_W;

  lbsc_pkg::state_t    state, state_next;
  logic [lbsc_pkg::CFG_W-1:0] radius;
  logic [R_W-1:0]      line_radius;
  logic [R_W-1:0]      pos, pos_next, pos_inc;
  logic [R_W-1:0]      flush_cnt, flush_cnt_next;
  lbsc_pkg::sample_t   last_sample;
  logic                out_valid;
  lbsc_pkg::sum_t      out_sum;
  logic                out_last;

  logic                can_emit, take, flush_step, advance, line_start;
  logic                emit, emit_last;
  logic [R_W-1:0]      radius_clamped, r_use;
  lbsc_pkg::sample_t   push, tail;
  lbsc_pkg::sum_t      total_next;
  lbsc_pkg::line_ctl_t ctl;

  always_comb begin
    if (int'(radius) > lbsc_pkg::MAX_RADIUS) begin
      radius_clamped = R_W'(lbsc_pkg::MAX_RADIUS);
    end else begin
      radius_clamped = R_W'(radius);
    end
    can_emit   = !out_valid || sums.ready;
    take       = (state == lbsc_pkg::ST_RUN) && samples.valid && can_emit;
    flush_step = (state == lbsc_pkg::ST_FLUSH) && can_emit;
    advance    = take || flush_step;
    line_start = take && (pos == '0);
    r_use      = line_start ? radius_clamped : line_radius;
    // During the flush the last sample is pushed again as the border.
    push       = (state == lbsc_pkg::ST_RUN) ? samples.sample : last_sample;
    emit       = advance && (pos >= r_use);
    emit_last  = (state == lbsc_pkg::ST_RUN) ? (samples.line_end && (r_use == '0))
                                             : (flush_cnt == R_W'(1));
    pos_inc    = (pos == R_W'(lbsc_pkg::MAX_RADIUS)) ? pos : pos + R_W'(1);

    ctl.fill   = line_start;
    ctl.shift  = advance;
    ctl.entry  = lbsc_pkg::IDX_W'(lbsc_pkg::STORE_DEPTH - 1) - lbsc_pkg::IDX_W'({r_use, 1'b0});
    ctl.sample = push;
  end

  always_comb begin
    state_next     = state;
    pos_next       = pos;
    flush_cnt_next = flush_cnt;
    unique case (state)
      lbsc_pkg::ST_RUN: begin
        if (take) begin
          if (samples.line_end && (r_use == '0)) begin
            pos_next = '0;
          end else if (samples.line_end) begin
            state_next     = lbsc_pkg::ST_FLUSH;
            flush_cnt_next = r_use;
            pos_next       = pos_inc;
          end else begin
            pos_next = pos_inc;
          end
        end
      end
      lbsc_pkg::ST_FLUSH: begin
        if (flush_step) begin
          flush_cnt_next = flush_cnt - R_W'(1);
          if (flush_cnt == R_W'(1)) begin
            state_next = lbsc_pkg::ST_RUN;
            pos_next   = '0;
          end else begin
            pos_next = pos_inc;
          end
        end
      end
      default: begin
        state_next = lbsc_pkg::ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= lbsc_pkg::ST_RUN;
      pos         <= '0;
      flush_cnt   <= '0;
      radius      <= lbsc_pkg::CFG_W'(1);
      line_radius <= R_W'(1);
      out_valid   <= 1'b0;
    end else begin
      state     <= state_next;
      pos       <= pos_next;
      flush_cnt <= flush_cnt_next;
      if (cfg_we) begin
        radius <= cfg_wdata;
      end
      if (line_start) begin
        line_radius <= radius_clamped;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (sums.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && samples.line_end) begin
      last_sample <= samples.sample;
    end
    if (emit) begin
      out_sum  <= total_next;
      out_last <= emit_last;
    end
  end

  lbsc_delay_line u_line (
    .clk  (clk),
    .ctl  (ctl),
    .tail (tail)
  );

  lbsc_accum u_accum (
    .clk        (clk),
    .fill       (line_start),
    .step       (advance),
    .radius     (r_use),
    .push       (push),
    .drop       (tail),
    .total_next (total_next)
  );

  assign samples.ready     = (state == lbsc_pkg::ST_RUN) && can_emit;
  assign sums.valid        = out_valid;
  assign sums.window_sum   = out_sum;
  assign sums.last_of_line = out_last;

  // A result is only written into a free or departing output register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    emit |-> can_emit)
    else $error("result written over one not yet taken");

  // The flush always has steps left while it is under way.
  a_flush_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == lbsc_pkg::ST_FLUSH) |-> (flush_cnt != '0))
    else $error("flush state with no steps left");

  // Ending a line returns the position to the start.
  a_line_restart: assert property (@(posedge clk) disable iff (rst)
    (emit && emit_last) |=> (pos == '0) && (state == lbsc_pkg::ST_RUN))
    else $error("line did not restart after its final result");

  // The radius in use changes only at the first sample of a line.
  a_radius_held: assert property (@(posedge clk) disable iff (rst)
    !line_start |=> $stable(line_radius))
    else $error("line radius changed mid-line");

  // The final flush step of a line always produces a result.
  a_flush_emits: assert property (@(posedge clk) disable iff (rst)
    (flush_step && (flush_cnt == R_W'(1))) |-> emit)
    else $error("final flush step gave no result");

endmodule
